>>> rtl/kvpi_pkg.sv
package kvpi_pkg;

    // Widths fixed by the item and register formats
    localparam int KIND_W     = 3;
    localparam int ADDR_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int ROW_W      = 4;
    localparam int BIT_W      = 3;
    localparam int MODE_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 24;
    localparam int FRAME_W    = 24;
    localparam int TONE_W     = 16;

    // Key matrix
    localparam int KEY_ROW_COUNT_DEF = 12;
    localparam int ROW_MODIFIER      = 10;
    localparam int ROW_REPEAT        = 11;
    localparam logic [ROW_W-1:0] KEY_SEL_LIMIT = 4'd10;

    // Port reset values
    localparam logic [BYTE_W-1:0] PORT_A_RESET = 8'h00;
    localparam logic [BYTE_W-1:0] PORT_B_RESET = 8'hFF;
    localparam logic [BYTE_W-1:0] PORT_C_RESET = 8'h4F;
    localparam logic [BYTE_W-1:0] CTRL_RESET   = 8'h8A;
    localparam logic [BYTE_W-1:0] ROW_RESET    = 8'hFF;

    // Accepted control bytes
    localparam logic [BYTE_W-1:0] CTRL_MODE_WORD = 8'h8A;
    localparam logic [BYTE_W-1:0] CTRL_BIT_CLR   = 8'h04;
    localparam logic [BYTE_W-1:0] CTRL_BIT_SET   = 8'h05;

    // Port C bit handling
    localparam logic [BYTE_W-1:0] C_FORCE_MASK  = 8'hD0;
    localparam logic [BYTE_W-1:0] C_TOGGLE_MASK = 8'h20;
    localparam logic [BYTE_W-1:0] C_HIGH_MASK   = 8'hF0;
    localparam int                C_FLYBACK_BIT = 7;
    localparam int                C_TONE_BIT    = 4;

    // Timebase register reset values
    localparam logic [FRAME_W-1:0] FRAME_PERIOD_RESET = 24'd16667;
    localparam logic [FRAME_W-1:0] FLYBACK_RESET      = 24'd833;
    localparam logic [TONE_W-1:0]  TONE_PERIOD_RESET  = 16'd417;
    localparam logic [TONE_W-1:0]  TONE_LOW_RESET     = 16'd208;

    localparam logic [MODE_W-1:0] MODE_MAX = 4'd8;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ     = 3'd0,
        KIND_WRITE    = 3'd1,
        KIND_KEY_DOWN = 3'd2,
        KIND_KEY_UP   = 3'd3,
        KIND_TICK     = 3'd4
    } t_kind;

    typedef enum logic [ADDR_W-1:0] {
        ADDR_PORT_A  = 2'd0,
        ADDR_PORT_B  = 2'd1,
        ADDR_PORT_C  = 2'd2,
        ADDR_CONTROL = 2'd3
    } t_addr;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_PERIOD  = 2'd0,
        CFG_FLYBACK_TICKS = 2'd1,
        CFG_TONE_PERIOD   = 2'd2,
        CFG_TONE_LOW      = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic [ROW_W-1:0]  key_row;
        logic [BIT_W-1:0]  key_bit;
    } t_item;

    typedef struct packed {
        logic flyback_low;
        logic tone_low;
    } t_wave;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic [MODE_W-1:0] video_mode;
        logic              mode_changed;
        logic              control_error;
    } t_result;

endpackage

>>> rtl/keyboard_video_port_interface.sv
// Keyboard and video parallel port.
// Input channel (i_in_valid / o_in_stall) carries bus reads and writes of
// ports A, B, C and control, key down / key up events, and timebase ticks.
// Output channel (o_out_valid / i_out_stall) returns exactly one result per
// item: read byte (zero unless a read), current video mode, a mode-change
// flag for port A writes and an error flag for unexpected control bytes.
// Config port (i_cfg_we / i_cfg_index / i_cfg_data) sets frame period,
// flyback length, tone period and tone low time; write only while idle.
// Path: an item transferred in passes through the input register, then
// the single-pass result register, before its result is on the output.
// Throughput: one item per cycle while i_out_stall is low; all the work is
// one pass of logic over the port registers, key matrix and two phase counters.
// Receiver stall: the result register holds; the item in the input register
// waits, and o_in_stall rises only while both stages are full.
// Reset (synchronous, active low): ports A/B/C/control = 00/FF/4F/8A, all
// key rows released, mode 0, both phases 0, config back to defaults, and
// both channel stages empty.
module keyboard_video_port_interface
    import kvpi_pkg::*;
#(
    parameter int KEY_ROW_COUNT = KEY_ROW_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [ADDR_W-1:0]    i_addr,
    input  logic [BYTE_W-1:0]    i_data,
    input  logic [ROW_W-1:0]     i_key_row,
    input  logic [BIT_W-1:0]     i_key_bit,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BYTE_W-1:0]    o_read_data,
    output logic [MODE_W-1:0]    o_video_mode,
    output logic                 o_mode_changed,
    output logic                 o_control_error
);

    logic    r_in_valid, n_in_valid;
    t_item   r_item;
    logic    r_out_valid, n_out_valid;
    t_result r_result;
    t_result result_c;
    t_wave   wave;
    logic    in_xfer;
    logic    advance;
    logic    tick;

    // Item moves into the result register when that register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign tick       = advance && (t_kind'(r_item.kind) == KIND_TICK);

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_xfer) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.kind    <= i_kind;
            r_item.addr    <= i_addr;
            r_item.data    <= i_data;
            r_item.key_row <= i_key_row;
            r_item.key_bit <= i_key_bit;
        end
        if (advance) begin
            r_result <= result_c;
        end
    end

    kvpi_timebase u_timebase (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tick      (tick),
        .o_wave      (wave)
    );

    kvpi_ports #(
        .KEY_ROW_COUNT (KEY_ROW_COUNT)
    ) u_ports (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_item),
        .i_wave    (wave),
        .o_result  (result_c)
    );

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_result.read_data;
    assign o_video_mode    = r_result.video_mode;
    assign o_mode_changed  = r_result.mode_changed;
    assign o_control_error = r_result.control_error;

    // A result taken into the output stage is presented next cycle
    a_advance_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("advanced item not presented");

    // Input side backs up only when the output stage is full and held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // A port A write and a control write are different items
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_mode_changed && o_control_error))
        else $error("mode change and control error in one result");

    // Mode code never leaves 0..8
    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_video_mode <= MODE_MAX))
        else $error("video mode out of range");

endmodule

>>> rtl/kvpi_timebase.sv
module kvpi_timebase
    import kvpi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_tick,
    output t_wave                o_wave
);

    logic [FRAME_W-1:0] r_frame_period;
    logic [FRAME_W-1:0] r_flyback_ticks;
    logic [TONE_W-1:0]  r_tone_period;
    logic [TONE_W-1:0]  r_tone_low_ticks;
    logic [FRAME_W-1:0] r_frame_phase, n_frame_phase;
    logic [TONE_W-1:0]  r_tone_phase, n_tone_phase;
    logic [FRAME_W:0]   frame_inc;
    logic [TONE_W:0]    tone_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_period   <= FRAME_PERIOD_RESET;
            r_flyback_ticks  <= FLYBACK_RESET;
            r_tone_period    <= TONE_PERIOD_RESET;
            r_tone_low_ticks <= TONE_LOW_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_PERIOD:  r_frame_period   <= i_cfg_data[FRAME_W-1:0];
                CFG_FLYBACK_TICKS: r_flyback_ticks  <= i_cfg_data[FRAME_W-1:0];
                CFG_TONE_PERIOD:   r_tone_period    <= i_cfg_data[TONE_W-1:0];
                CFG_TONE_LOW:      r_tone_low_ticks <= i_cfg_data[TONE_W-1:0];
                default: ;
            endcase
        end
    end

    // Wrap at the period; a period of 0 or 1 pins the phase at 0
    always_comb begin
        frame_inc     = {1'b0, r_frame_phase} + {{FRAME_W{1'b0}}, 1'b1};
        tone_inc      = {1'b0, r_tone_phase} + {{TONE_W{1'b0}}, 1'b1};
        n_frame_phase = r_frame_phase;
        n_tone_phase  = r_tone_phase;
        if (i_tick) begin
            n_frame_phase = (frame_inc >= {1'b0, r_frame_period}) ? '0
                                                                  : frame_inc[FRAME_W-1:0];
            n_tone_phase  = (tone_inc >= {1'b0, r_tone_period}) ? '0
                                                                : tone_inc[TONE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_phase <= '0;
            r_tone_phase  <= '0;
        end else begin
            r_frame_phase <= n_frame_phase;
            r_tone_phase  <= n_tone_phase;
        end
    end

    assign o_wave.flyback_low = (r_frame_phase < r_flyback_ticks);
    assign o_wave.tone_low    = (r_tone_phase < r_tone_low_ticks);

endmodule

>>> rtl/kvpi_ports.sv
module kvpi_ports
    import kvpi_pkg::*;
#(
    parameter int KEY_ROW_COUNT = KEY_ROW_COUNT_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_item   i_item,
    input  t_wave   i_wave,
    output t_result o_result
);

    localparam int ROW_IDX_W = $clog2(KEY_ROW_COUNT);

    logic [BYTE_W-1:0] r_port_a, n_port_a;
    logic [BYTE_W-1:0] r_port_b, n_port_b;
    logic [BYTE_W-1:0] r_port_c, n_port_c;
    logic [BYTE_W-1:0] r_ctrl, n_ctrl;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic [BYTE_W-1:0] r_key_rows [KEY_ROW_COUNT];
    logic [BYTE_W-1:0] n_key_rows [KEY_ROW_COUNT];

    t_kind             kind_c;
    t_addr             addr_c;
    logic [ROW_W-1:0]  sel;
    logic [BYTE_W-1:0] port_b_val;
    logic [BYTE_W-1:0] port_c_val;
    logic [MODE_W-1:0] mode_wr;

    // Odd high nibble n gives mode (n+1)/2, even gives mode 0
    function automatic logic [MODE_W-1:0] mode_of(input logic [BYTE_W-1:0] a);
        logic [MODE_W:0] sum;
        sum = {1'b0, a[7:4]} + {{MODE_W{1'b0}}, 1'b1};
        return a[4] ? sum[MODE_W:1] : '0;
    endfunction

    assign kind_c  = t_kind'(i_item.kind);
    assign addr_c  = t_addr'(i_item.addr);
    assign sel     = r_port_a[ROW_W-1:0];
    assign mode_wr = mode_of(i_item.data);

    always_comb begin
        port_b_val = r_key_rows[ROW_MODIFIER];
        if (sel < KEY_SEL_LIMIT) begin
            port_b_val = r_key_rows[sel[ROW_IDX_W-1:0]] & r_key_rows[ROW_MODIFIER];
        end
        port_c_val = (r_port_c | C_FORCE_MASK) & r_key_rows[ROW_REPEAT];
        if (i_wave.flyback_low) begin
            port_c_val[C_FLYBACK_BIT] = 1'b0;
        end
        if (i_wave.tone_low) begin
            port_c_val[C_TONE_BIT] = 1'b0;
        end
        port_c_val = port_c_val ^ C_TOGGLE_MASK;
    end

    always_comb begin
        n_port_a   = r_port_a;
        n_port_b   = r_port_b;
        n_port_c   = r_port_c;
        n_ctrl     = r_ctrl;
        n_mode     = r_mode;
        n_key_rows = r_key_rows;
        o_result   = '0;
        case (kind_c)
            KIND_READ: begin
                case (addr_c)
                    ADDR_PORT_A:  o_result.read_data = r_port_a;
                    ADDR_PORT_B: begin
                        n_port_b           = port_b_val;
                        o_result.read_data = port_b_val;
                    end
                    ADDR_PORT_C: begin
                        n_port_c           = port_c_val;
                        o_result.read_data = port_c_val;
                    end
                    ADDR_CONTROL: o_result.read_data = r_ctrl;
                    default: ;
                endcase
            end
            KIND_WRITE: begin
                case (addr_c)
                    ADDR_PORT_A: begin
                        o_result.mode_changed = (mode_wr != r_mode);
                        n_mode                = mode_wr;
                        n_port_a              = i_item.data;
                    end
                    ADDR_PORT_B: n_port_b = i_item.data;
                    ADDR_PORT_C: n_port_c = (i_item.data & ~C_HIGH_MASK)
                                          | (r_port_c & C_HIGH_MASK);
                    ADDR_CONTROL: begin
                        case (i_item.data) inside
                            CTRL_MODE_WORD, CTRL_BIT_CLR, CTRL_BIT_SET: ;
                            default: o_result.control_error = 1'b1;
                        endcase
                        n_ctrl = i_item.data;
                    end
                    default: ;
                endcase
            end
            KIND_KEY_DOWN, KIND_KEY_UP: begin
                // Rows past the matrix never match and are ignored
                for (int r = 0; r < KEY_ROW_COUNT; r++) begin
                    if (i_item.key_row == ROW_W'(r)) begin
                        n_key_rows[r][i_item.key_bit] = (kind_c == KIND_KEY_UP);
                    end
                end
            end
            default: ;
        endcase
        o_result.video_mode = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_a <= PORT_A_RESET;
            r_port_b <= PORT_B_RESET;
            r_port_c <= PORT_C_RESET;
            r_ctrl   <= CTRL_RESET;
            r_mode   <= '0;
            for (int r = 0; r < KEY_ROW_COUNT; r++) begin
                r_key_rows[r] <= ROW_RESET;
            end
        end else if (i_advance) begin
            r_port_a   <= n_port_a;
            r_port_b   <= n_port_b;
            r_port_c   <= n_port_c;
            r_ctrl     <= n_ctrl;
            r_mode     <= n_mode;
            r_key_rows <= n_key_rows;
        end
    end

endmodule
